/* hw/rtl/bqd_pkg.sv */
// ----------------------------------------------------------------------------
// bqd_pkg
// Shared types, fixed-point constants and the microcode program of the
// biquad section.
// ----------------------------------------------------------------------------
package bqd_pkg;

    // Fixed-point formats
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 32;
    localparam int COEF_FRAC   = 30;
    localparam int STATE_BITS  = 48;
    localparam int STATE_FRAC  = 39;

    localparam int PROD_BITS  = SAMPLE_BITS + COEF_BITS;
    localparam int PROD_SHIFT = SAMPLE_BITS - 1 + COEF_FRAC - STATE_FRAC;
    localparam int TERM_BITS  = PROD_BITS + 1 - PROD_SHIFT;
    localparam int ACC_BITS   = STATE_BITS + 3;
    localparam int OUT_SHIFT  = STATE_FRAC - (SAMPLE_BITS - 1);
    localparam int RND_BITS   = ACC_BITS + 1 - OUT_SHIFT;

    localparam logic [PROD_BITS:0] PROD_HALF =
        {{(PROD_BITS + 1 - PROD_SHIFT){1'b0}}, 1'b1, {(PROD_SHIFT - 1){1'b0}}};
    localparam logic [ACC_BITS:0] OUT_HALF =
        {{(ACC_BITS + 1 - OUT_SHIFT){1'b0}}, 1'b1, {(OUT_SHIFT - 1){1'b0}}};

    localparam int MAX_CHANNELS_DEF = 2;

    // Configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CH_COUNT_BITS  = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_B0,
        CFG_B1,
        CFG_B2,
        CFG_A1,
        CFG_A2,
        CFG_CHANNELS
    } cfg_index_t;

    localparam logic signed [COEF_BITS-1:0] COEF_ONE  = 32'sh4000_0000;
    localparam logic signed [COEF_BITS-1:0] COEF_ZERO = 32'sh0000_0000;
    localparam logic [CH_COUNT_BITS-1:0]    CH_COUNT_RESET = 2'd2;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] b0;
        logic signed [COEF_BITS-1:0] b1;
        logic signed [COEF_BITS-1:0] b2;
        logic signed [COEF_BITS-1:0] a1;
        logic signed [COEF_BITS-1:0] a2;
    } coef_set_t;

    // Channel words
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          channel;
    } sample_word_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          channel_out;
    } result_word_t;

    // Sequencer
    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    localparam int STEP_BITS = 4;
    typedef logic [STEP_BITS-1:0] step_t;

    typedef enum logic [2:0] {
        COEF_SEL_B0,
        COEF_SEL_B1,
        COEF_SEL_B2,
        COEF_SEL_A1,
        COEF_SEL_A2
    } coef_sel_t;

    typedef enum logic {
        MUL_X,
        MUL_Y
    } mul_src_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD_D1,
        ACC_ADD_D2,
        ACC_SUB
    } acc_op_t;

    typedef enum logic {
        COND_NONE,
        COND_BYPASS
    } jump_cond_t;

    typedef struct packed {
        logic       mul_en;
        coef_sel_t  coef_sel;
        mul_src_t   mul_src;
        logic       term_en;
        acc_op_t    acc_a_op;
        acc_op_t    acc_b_op;
        logic       y_en;
        logic       d1_wr;
        logic       d2_wr;
        logic       emit;
        jump_cond_t cond;
        step_t      target;
        logic       last;
    } ucode_t;

    localparam ucode_t UCODE_NOP = '{
        mul_en:   1'b0,
        coef_sel: COEF_SEL_B0,
        mul_src:  MUL_X,
        term_en:  1'b0,
        acc_a_op: ACC_HOLD,
        acc_b_op: ACC_HOLD,
        y_en:     1'b0,
        d1_wr:    1'b0,
        d2_wr:    1'b0,
        emit:     1'b0,
        cond:     COND_NONE,
        target:   '0,
        last:     1'b0
    };

    localparam step_t STEP_EMIT = 4'd8;

    // The program. The multiplier result lands in the product register, is then
    // rounded into the term register and from there accumulated, so successive
    // products overlap in these stages.
    function automatic ucode_t ucode_word(input step_t step);
        ucode_t w;
        begin
            w = UCODE_NOP;
            unique case (step)
                4'd0:
                begin
                    // b0*x; channels not in use go straight to the result
                    w.mul_en   = 1'b1;
                    w.coef_sel = COEF_SEL_B0;
                    w.cond     = COND_BYPASS;
                    w.target   = STEP_EMIT;
                end
                4'd1:
                begin
                    w.term_en  = 1'b1;
                    w.mul_en   = 1'b1;
                    w.coef_sel = COEF_SEL_B1;
                end
                4'd2:
                begin
                    w.acc_a_op = ACC_ADD_D1;
                    w.term_en  = 1'b1;
                    w.mul_en   = 1'b1;
                    w.coef_sel = COEF_SEL_B2;
                end
                4'd3:
                begin
                    w.y_en     = 1'b1;
                    w.acc_a_op = ACC_ADD_D2;
                    w.term_en  = 1'b1;
                end
                4'd4:
                begin
                    w.acc_b_op = ACC_LOAD;
                    w.mul_en   = 1'b1;
                    w.coef_sel = COEF_SEL_A1;
                    w.mul_src  = MUL_Y;
                end
                4'd5:
                begin
                    w.term_en  = 1'b1;
                    w.mul_en   = 1'b1;
                    w.coef_sel = COEF_SEL_A2;
                    w.mul_src  = MUL_Y;
                end
                4'd6:
                begin
                    w.acc_a_op = ACC_SUB;
                    w.term_en  = 1'b1;
                end
                4'd7:
                begin
                    w.acc_b_op = ACC_SUB;
                    w.d1_wr    = 1'b1;
                end
                STEP_EMIT:
                begin
                    w.d2_wr = 1'b1;
                    w.emit  = 1'b1;
                    w.last  = 1'b1;
                end
                default:
                begin
                    w.last = 1'b1;
                end
            endcase
            return w;
        end
    endfunction

endpackage

/* hw/rtl/bqd_sequencer.sv */
// ----------------------------------------------------------------------------
// bqd_sequencer
// Step counter and microcode lookup that drive the biquad datapath.
// ----------------------------------------------------------------------------
module bqd_sequencer
    import bqd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  logic   active,
    input  logic   out_free,
    output logic   busy,
    output ucode_t ctrl
);

    seq_state_t state_reg, state_next;
    step_t      step_reg, step_next;
    logic       active_reg, active_next;
    ucode_t     word;
    logic       hold;

    assign word = ucode_word(step_reg);
    assign hold = word.emit && !out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SEQ_IDLE;
            step_reg   <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            active_reg <= active_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        active_next = active_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (start)
                begin
                    state_next  = SEQ_RUN;
                    step_next   = '0;
                    active_next = active;
                end
            end
            SEQ_RUN:
            begin
                priority if (hold)
                begin
                    step_next = step_reg;
                end
                else if (word.last)
                begin
                    state_next = SEQ_IDLE;
                end
                else if (word.cond == COND_BYPASS && !active_reg)
                begin
                    step_next = word.target;
                end
                else
                begin
                    step_next = step_t'(step_reg + 1'b1);
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        busy = 1'b1;
        ctrl = UCODE_NOP;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                busy = 1'b0;
            end
            SEQ_RUN:
            begin
                if (!hold)
                begin
                    ctrl       = word;
                    ctrl.d1_wr = word.d1_wr && active_reg;
                    ctrl.d2_wr = word.d2_wr && active_reg;
                end
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

/* hw/rtl/bqd_datapath.sv */
// ----------------------------------------------------------------------------
// bqd_datapath
// Shared multiplier, rounding stage, two accumulators and per-channel delay
// state, all steered by the microcode word.
// ----------------------------------------------------------------------------
module bqd_datapath
    import bqd_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  sample_word_t in_word,
    input  coef_set_t    coefs,
    input  ucode_t       ctrl,
    output result_word_t result
);

    localparam int IDX_BITS = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg, y_next;
    logic                          ch_reg;
    logic signed [PROD_BITS-1:0]   prod_reg, prod_next;
    logic signed [TERM_BITS-1:0]   term_reg, term_next;
    logic signed [ACC_BITS-1:0]    acc_a_reg, acc_a_next;
    logic signed [ACC_BITS-1:0]    acc_b_reg, acc_b_next;
    logic signed [STATE_BITS-1:0]  d1_reg [MAX_CHANNELS];
    logic signed [STATE_BITS-1:0]  d2_reg [MAX_CHANNELS];
    logic signed [STATE_BITS-1:0]  d1_next, d2_next;

    logic [IDX_BITS-1:0]           ch_idx;
    logic signed [COEF_BITS-1:0]   coef_op;
    logic signed [SAMPLE_BITS-1:0] mul_op;
    logic [PROD_BITS:0]            prod_sum;
    logic signed [ACC_BITS-1:0]    term_ext, d1_ext, d2_ext;
    logic [ACC_BITS:0]             y_sum;
    logic [RND_BITS-1:0]           y_rnd;
    logic [RND_BITS-SAMPLE_BITS:0] y_top;

    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [ACC_BITS-1:0] v
    );
        logic [ACC_BITS-STATE_BITS:0] top;
        begin
            top = v[ACC_BITS-1:STATE_BITS-1];
            if (&top || ~|top)
                return v[STATE_BITS-1:0];
            return {v[ACC_BITS-1], {(STATE_BITS-1){~v[ACC_BITS-1]}}};
        end
    endfunction

    assign ch_idx = IDX_BITS'(ch_reg);

    // Multiplier operands
    always_comb
    begin
        unique case (ctrl.coef_sel)
            COEF_SEL_B0: coef_op = coefs.b0;
            COEF_SEL_B1: coef_op = coefs.b1;
            COEF_SEL_B2: coef_op = coefs.b2;
            COEF_SEL_A1: coef_op = coefs.a1;
            COEF_SEL_A2: coef_op = coefs.a2;
            default:     coef_op = coefs.b0;
        endcase
    end

    assign mul_op    = (ctrl.mul_src == MUL_Y) ? y_reg : x_reg;
    assign prod_next = coef_op * mul_op;

    // Round half up to the state fraction
    assign prod_sum  = {prod_reg[PROD_BITS-1], prod_reg} + PROD_HALF;
    assign term_next = prod_sum[PROD_BITS:PROD_SHIFT];

    assign term_ext = {{(ACC_BITS-TERM_BITS){term_reg[TERM_BITS-1]}}, term_reg};
    assign d1_ext   = {{(ACC_BITS-STATE_BITS){d1_reg[ch_idx][STATE_BITS-1]}},
                       d1_reg[ch_idx]};
    assign d2_ext   = {{(ACC_BITS-STATE_BITS){d2_reg[ch_idx][STATE_BITS-1]}},
                       d2_reg[ch_idx]};

    always_comb
    begin
        unique case (ctrl.acc_a_op)
            ACC_LOAD:   acc_a_next = term_ext;
            ACC_ADD_D1: acc_a_next = term_ext + d1_ext;
            ACC_ADD_D2: acc_a_next = term_ext + d2_ext;
            ACC_SUB:    acc_a_next = acc_a_reg - term_ext;
            default:    acc_a_next = acc_a_reg;
        endcase
    end

    always_comb
    begin
        unique case (ctrl.acc_b_op)
            ACC_LOAD:   acc_b_next = term_ext;
            ACC_ADD_D1: acc_b_next = term_ext + d1_ext;
            ACC_ADD_D2: acc_b_next = term_ext + d2_ext;
            ACC_SUB:    acc_b_next = acc_b_reg - term_ext;
            default:    acc_b_next = acc_b_reg;
        endcase
    end

    // Output sample: round to the sample fraction, then saturate
    assign y_sum = {acc_a_reg[ACC_BITS-1], acc_a_reg} + OUT_HALF;
    assign y_rnd = y_sum[ACC_BITS:OUT_SHIFT];
    assign y_top = y_rnd[RND_BITS-1:SAMPLE_BITS-1];

    always_comb
    begin
        if (&y_top || ~|y_top)
            y_next = y_rnd[SAMPLE_BITS-1:0];
        else
            y_next = {y_rnd[RND_BITS-1], {(SAMPLE_BITS-1){~y_rnd[RND_BITS-1]}}};
    end

    assign d1_next = sat_state(acc_a_reg);
    assign d2_next = sat_state(acc_b_reg);

    // Working registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg  <= in_word.sample_in;
            ch_reg <= in_word.channel;
            y_reg  <= in_word.sample_in;
        end
        else if (ctrl.y_en)
        begin
            y_reg <= y_next;
        end
        if (ctrl.mul_en)
            prod_reg <= prod_next;
        if (ctrl.term_en)
            term_reg <= term_next;
        acc_a_reg <= acc_a_next;
        acc_b_reg <= acc_b_next;
    end

    // Delay state per channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                d1_reg[i] <= '0;
                d2_reg[i] <= '0;
            end
        end
        else
        begin
            if (ctrl.d1_wr)
                d1_reg[ch_idx] <= d1_next;
            if (ctrl.d2_wr)
                d2_reg[ch_idx] <= d2_next;
        end
    end

    assign result = '{sample_out: y_reg, channel_out: ch_reg};

endmodule

/* hw/rtl/biquad_iir_section.sv */
// ----------------------------------------------------------------------------
// biquad_iir_section
// Second-order IIR section in transposed direct form II, fixed point, with
// a separate pair of delay values for each audio channel.
// ----------------------------------------------------------------------------
// Each input word carries a signed Q1.23 sample and a channel index and gives
// exactly one result word with the filtered sample on the same channel. The
// five coefficients are signed Q2.30 and come up as the identity filter; the
// delay state is 48 bits with 39 fraction bits and saturates, and the output
// is rounded half up and saturated to 24 bits. Samples on a channel at or
// above the channels-in-use register (or at or above MAX_CHANNELS) pass
// through unchanged and leave the state alone. A filtered word runs through
// the nine microcode steps, as the single multiplier forms the five products
// in turn with a rounding stage and an accumulate stage behind it. The
// sequencer returns to idle after the last step and only then accepts again,
// so it takes no new word before it is through with the last. A pass-through
// word jumps from the first step straight to the last one. The next word is
// taken once the program has finished, even while the previous result still
// waits on a stalled output; the program only pauses on its last step if the
// result register is still full at that point. Configuration must be written
// only while the block is idle; the block itself does not enforce this.
module biquad_iir_section
    import bqd_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  sample_word_t              in_word,

    output logic                      out_valid,
    input  logic                      out_stall,
    output result_word_t              out_word
);

    coef_set_t                coefs_reg;
    logic [CH_COUNT_BITS-1:0] ch_count_reg;

    logic         start;
    logic         active;
    logic         busy;
    logic         out_free;
    ucode_t       ctrl;
    result_word_t result;

    logic         out_valid_reg;
    result_word_t out_word_reg;

    // Configuration registers. Indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg.b0 <= COEF_ONE;
            coefs_reg.b1 <= COEF_ZERO;
            coefs_reg.b2 <= COEF_ZERO;
            coefs_reg.a1 <= COEF_ZERO;
            coefs_reg.a2 <= COEF_ZERO;
            ch_count_reg <= CH_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_B0:       coefs_reg.b0 <= cfg_data;
                CFG_B1:       coefs_reg.b1 <= cfg_data;
                CFG_B2:       coefs_reg.b2 <= cfg_data;
                CFG_A1:       coefs_reg.a1 <= cfg_data;
                CFG_A2:       coefs_reg.a2 <= cfg_data;
                CFG_CHANNELS: ch_count_reg <= cfg_data[CH_COUNT_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // A word is taken whenever the sequencer is idle.
    assign in_stall = busy;
    assign start    = in_valid && !busy;

    // A channel is filtered only when it lies below both the register's
    // count and the number of state sets built in. Because both limits must
    // hold, a count above MAX_CHANNELS behaves as MAX_CHANNELS.
    assign active = ({1'b0, in_word.channel} < ch_count_reg)
                 && (32'(in_word.channel) < MAX_CHANNELS);

    // The result register is free if empty or being taken in this cycle.
    assign out_free = !out_valid_reg || !out_stall;

    bqd_sequencer u_sequencer (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .active   (active),
        .out_free (out_free),
        .busy     (busy),
        .ctrl     (ctrl)
    );

    bqd_datapath #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .in_word (in_word),
        .coefs   (coefs_reg),
        .ctrl    (ctrl),
        .result  (result)
    );

    // Output register: parts the sequencer from a stalling consumer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
            out_word_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule
